FILE: rtl/csfp_pkg.sv
// Shared types and constants of the checksummed serial frame parser.
package csfp_pkg;

  // Framing bytes and length limits
  localparam logic [7:0] SYNC_FIRST   = 8'h55;
  localparam logic [7:0] SYNC_SECOND  = 8'h00;
  localparam logic [7:0] TRAIL_FIRST  = 8'h00;
  localparam logic [7:0] TRAIL_SECOND = 8'hAA;
  localparam logic [7:0] MIN_LEN      = 8'd9;
  localparam logic [7:0] LEN_OVERHEAD = 8'd8;
  localparam logic [7:0] CHECK_BASE   = 8'd255;

  // Result kind codes
  localparam logic [2:0] KIND_PAYLOAD     = 3'd0;
  localparam logic [2:0] KIND_GOOD        = 3'd1;
  localparam logic [2:0] KIND_BAD_CHECK   = 3'd2;
  localparam logic [2:0] KIND_BAD_TRAILER = 3'd3;
  localparam logic [2:0] KIND_BAD_LENGTH  = 3'd4;

  // Byte held in the input stage
  typedef struct packed {
    logic       valid;
    logic [7:0] rx_byte;
  } csfp_item_t;

  // One result of the deframer, as packed onto the output channel
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] payload_length;
    logic [7:0] frame_address;
    logic [7:0] frame_kind;
    logic [7:0] payload_index;
    logic [7:0] payload_byte;
  } csfp_result_t;

endpackage

FILE: rtl/csfp_in_stage.sv
// Input register of the frame parser: holds one received byte until consumed.
module csfp_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                tvalid_i,
  output logic                tready_o,
  input  logic [7:0]          tdata_i,
  input  logic                advance_i,
  output csfp_pkg::csfp_item_t item_o
);

  logic       valid_q;
  logic [7:0] byte_q;

  assign tready_o = !valid_q || advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (tready_o) begin
      valid_q <= tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tready_o && tvalid_i) begin
      byte_q <= tdata_i;
    end
  end

  assign item_o.valid   = valid_q;
  assign item_o.rx_byte = byte_q;

endmodule

FILE: rtl/csfp_deframer.sv
// Frame state machine with running checksum; computes at most one result per byte.
module csfp_deframer (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic [7:0]            rx_byte_i,
  output logic                  res_valid_o,
  output csfp_pkg::csfp_result_t res_o
);

  typedef enum logic [3:0] {
    PH_HUNT   = 4'd0,
    PH_SYNC2  = 4'd1,
    PH_LEN    = 4'd2,
    PH_TYPE   = 4'd3,
    PH_ADDR   = 4'd4,
    PH_DATA   = 4'd5,
    PH_CHECK  = 4'd6,
    PH_TRAIL1 = 4'd7,
    PH_TRAIL2 = 4'd8
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [7:0] len_q, len_d;
  logic [7:0] type_q, type_d;
  logic [7:0] addr_q, addr_d;
  logic [7:0] count_q, count_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] pay_len;
  logic [7:0] count_inc;

  assign pay_len   = len_q - csfp_pkg::LEN_OVERHEAD;
  assign count_inc = count_q + 8'd1;

  always_comb begin
    phase_d = phase_q;
    len_d   = len_q;
    type_d  = type_q;
    addr_d  = addr_q;
    count_d = count_q;
    sum_d   = sum_q;

    res_valid_o          = 1'b0;
    res_o.kind           = csfp_pkg::KIND_PAYLOAD;
    res_o.payload_byte   = '0;
    res_o.payload_index  = '0;
    res_o.frame_kind     = type_q;
    res_o.frame_address  = addr_q;
    res_o.payload_length = pay_len;

    case (phase_q)
      PH_SYNC2: begin
        if (rx_byte_i == csfp_pkg::SYNC_SECOND) begin
          phase_d = PH_LEN;
        end else if (rx_byte_i == csfp_pkg::SYNC_FIRST) begin
          phase_d = PH_SYNC2;
        end else begin
          phase_d = PH_HUNT;
        end
      end
      PH_LEN: begin
        if (rx_byte_i < csfp_pkg::MIN_LEN) begin
          res_valid_o          = 1'b1;
          res_o.kind           = csfp_pkg::KIND_BAD_LENGTH;
          res_o.frame_kind     = '0;
          res_o.frame_address  = '0;
          res_o.payload_length = '0;
          phase_d              = PH_HUNT;
        end else begin
          len_d   = rx_byte_i;
          sum_d   = rx_byte_i;
          phase_d = PH_TYPE;
        end
      end
      PH_TYPE: begin
        type_d  = rx_byte_i;
        sum_d   = sum_q + rx_byte_i;
        phase_d = PH_ADDR;
      end
      PH_ADDR: begin
        addr_d  = rx_byte_i;
        sum_d   = sum_q + rx_byte_i;
        count_d = '0;
        phase_d = PH_DATA;
      end
      PH_DATA: begin
        res_valid_o         = 1'b1;
        res_o.kind          = csfp_pkg::KIND_PAYLOAD;
        res_o.payload_byte  = rx_byte_i;
        res_o.payload_index = count_q;
        sum_d               = sum_q + rx_byte_i;
        count_d             = count_inc;
        if (count_inc == pay_len) begin
          phase_d = PH_CHECK;
        end
      end
      PH_CHECK: begin
        if (rx_byte_i == (csfp_pkg::CHECK_BASE - sum_q)) begin
          phase_d = PH_TRAIL1;
        end else begin
          res_valid_o = 1'b1;
          res_o.kind  = csfp_pkg::KIND_BAD_CHECK;
          phase_d     = PH_HUNT;
        end
      end
      PH_TRAIL1: begin
        if (rx_byte_i == csfp_pkg::TRAIL_FIRST) begin
          phase_d = PH_TRAIL2;
        end else begin
          res_valid_o = 1'b1;
          res_o.kind  = csfp_pkg::KIND_BAD_TRAILER;
          phase_d     = PH_HUNT;
        end
      end
      PH_TRAIL2: begin
        res_valid_o = 1'b1;
        res_o.kind  = (rx_byte_i == csfp_pkg::TRAIL_SECOND) ? csfp_pkg::KIND_GOOD
                                                            : csfp_pkg::KIND_BAD_TRAILER;
        phase_d     = PH_HUNT;
      end
      default: begin
        // hunting, and any unused phase code
        phase_d = (rx_byte_i == csfp_pkg::SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      len_q   <= '0;
      type_q  <= '0;
      addr_q  <= '0;
      count_q <= '0;
      sum_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      len_q   <= len_d;
      type_q  <= type_d;
      addr_q  <= addr_d;
      count_q <= count_d;
      sum_q   <= sum_d;
    end
  end

endmodule

FILE: rtl/checksummed_serial_frame_parser_top.sv
// Top level of the checksummed serial frame parser: input stage, deframer, result register.
//
//  channel  | dir | tdata (low bit up)                         | tuser
//  ---------+-----+--------------------------------------------+-------------
//  s_axis   | in  | rx_byte[7:0]                               | -
//  m_axis   | out | payload_byte, payload_index, frame_kind,   | kind[2:0]
//           |     | frame_address, payload_length (40 bits)    |
//
// One byte per cycle sustained while results are taken; the deframer works on the byte
// in the input register and writes its result, if any, to the result register as
// that byte advances out of it, and the result is offered from the result register.
// Reset clears the frame state to hunting and empties both registers.
// While a result waits untaken, hold the byte in the input register, result or
// not; an empty input register takes one more byte, then the input stalls.
module checksummed_serial_frame_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // received bytes
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  // payload bytes and frame status
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [7:0] payload_byte, [15:8] payload_index,
                                        // [23:16] frame_kind, [31:24] frame_address,
                                        // [39:32] payload_length
  output logic [2:0]  m_axis_tuser_o    // [2:0] kind
);

  csfp_pkg::csfp_item_t   item;
  csfp_pkg::csfp_result_t res;
  logic                   res_valid;
  logic                   advance;
  logic                   out_free;

  logic                   out_valid_q;
  csfp_pkg::csfp_result_t out_q;

  // The output slot is free when empty or being drained this cycle
  assign out_free = !out_valid_q || m_axis_tready_i;
  // Advance the held byte only when its result, if any, has somewhere to go
  assign advance  = item.valid && out_free;

  csfp_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tvalid_i  (s_axis_tvalid_i),
    .tready_o  (s_axis_tready_o),
    .tdata_i   (s_axis_tdata_i),
    .advance_i (advance),
    .item_o    (item)
  );

  csfp_deframer u_deframer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .rx_byte_i   (item.rx_byte),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Result register valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance && res_valid;
    end
  end

  // Result payload: load only with a fresh result
  always_ff @(posedge clk_i) begin
    if (out_free && advance && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.kind;
  assign m_axis_tdata_o  = {out_q.payload_length, out_q.frame_address, out_q.frame_kind,
                            out_q.payload_index, out_q.payload_byte};

endmodule
